>>> design/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define FCA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fca assertion failed");

// Condition in one cycle implies a condition in the next.
`define FCA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("fca sequence assertion failed");

`endif

>>> design/fca_pkg.sv
// Shared types and constants of the link table allocator.
package fca_pkg;

  localparam int unsigned FIELD_W = 12;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_FORMAT = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  // Classified job handed from front to back
  typedef enum logic [2:0] {
    OP_FORMAT,
    OP_ALLOC,
    OP_FREE,
    OP_LOOKUP,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [FIELD_W-1:0] count;
    logic [FIELD_W-1:0] index;
  } job_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_COUNT,
    BK_LINK,
    BK_TERM,
    BK_FREE,
    BK_LOOK,
    BK_RESP
  } bk_state_e;

endpackage

>>> design/fca_chan_if.sv
// Request and result channel interfaces of the allocator.
interface fca_req_if import fca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [FIELD_W-1:0] block_count;
  logic [FIELD_W-1:0] start_block;

  modport source (output valid, output mode, output block_count, output start_block,
                  input ready);
  modport sink   (input valid, input mode, input block_count, input start_block,
                  output ready);
endinterface

interface fca_rsp_if import fca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [FIELD_W-1:0] first_block;
  logic [FIELD_W-1:0] next_block;
  logic               is_end;
  logic [FIELD_W-1:0] freed_count;

  modport source (output valid, output status, output first_block, output next_block,
                  output is_end, output freed_count, input ready);
  modport sink   (input valid, input status, input first_block, input next_block,
                  input is_end, input freed_count, output ready);
endinterface

>>> design/fca_front.sv
// Request front end: classifies requests and queues jobs for the back end.
`include "assert_macros.svh"

module fca_front import fca_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fca_req_if.sink    req_i,
  input  logic       init_busy_i,
  output logic       job_valid_o,
  output job_t       job_o,
  input  logic       job_ready_i
);

  job_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  logic              idx_oor;
  job_t              job_new;

  assign req_i.ready = !init_busy_i && (cnt_q != QCNT_W'(QDEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign pop         = job_valid_o && job_ready_i;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem[rd_ptr_q];

  // Classify: bad requests are settled here and skip the table entirely
  always_comb begin
    idx_oor       = ({20'd0, req_i.start_block} >= TABLE_ENTRIES);
    job_new.count = req_i.block_count;
    job_new.index = req_i.start_block;
    unique case (mode_e'(req_i.mode))
      MODE_FORMAT: job_new.op = OP_FORMAT;
      MODE_ALLOC:  job_new.op = (req_i.block_count == '0) ? OP_REJECT : OP_ALLOC;
      MODE_FREE: begin
        job_new.op = (req_i.start_block == '0 || idx_oor) ? OP_REJECT : OP_FREE;
      end
      MODE_LOOKUP: job_new.op = idx_oor ? OP_REJECT : OP_LOOKUP;
      default:     job_new.op = OP_REJECT;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= job_new;
    end
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `FCA_ASSERT(a_q_bound, cnt_q <= QCNT_W'(QDEPTH))
  `FCA_ASSERT_NEXT(a_q_push, push && !pop, cnt_q == $past(cnt_q) + QCNT_W'(1))

endmodule

>>> design/fca_back.sv
// Back end: link table memory and the sequencer that carries out jobs.
`include "assert_macros.svh"

module fca_back import fca_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_ready_o,
  output logic       init_busy_o,
  fca_rsp_if.source  rsp_o
);

  localparam int unsigned IDXW = $clog2(TABLE_ENTRIES);
  localparam int unsigned EW   = IDXW + 1;
  localparam logic [IDXW-1:0] LAST_IDX   = IDXW'(TABLE_ENTRIES - 1);
  localparam logic [IDXW:0]   ENTRIES_W  = (IDXW + 1)'(TABLE_ENTRIES);
  localparam logic [EW-1:0]   END_ENTRY  = {1'b1, {IDXW{1'b0}}};

  // Entry: {end mark, link}; all zero means free
  logic [EW-1:0] mem [TABLE_ENTRIES];

  bk_state_e          state_q, state_d;
  logic [IDXW-1:0]    addr_q, addr_d;
  logic               iss_done_q, iss_done_d;
  logic               fmt_q, fmt_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDXW-1:0]    rd_addr_q;
  logic [EW-1:0]      rdata_q;
  logic [FIELD_W-1:0] count_q, count_d;
  logic [FIELD_W-1:0] found_q, found_d;
  logic [IDXW-1:0]    prev_q, prev_d;
  logic [IDXW-1:0]    head_q, head_d;
  status_e            status_q, status_d;
  logic [FIELD_W-1:0] first_q, first_d;
  logic [FIELD_W-1:0] next_q, next_d;
  logic               end_q, end_d;
  logic [FIELD_W-1:0] freed_q, freed_d;

  logic               we, re;
  logic [IDXW-1:0]    waddr, raddr;
  logic [EW-1:0]      wdata;

  logic               rd_free, rd_last, hit_last, clr_last;
  logic               link_end, link_bad;
  logic [IDXW-1:0]    link_idx;

  assign rd_free  = rd_vld_q && (rdata_q == '0);
  assign rd_last  = rd_vld_q && (rd_addr_q == LAST_IDX);
  assign hit_last = rd_free && ((found_q + FIELD_W'(1)) == count_q);
  assign clr_last = (addr_q == LAST_IDX);
  assign link_end = rdata_q[IDXW];
  assign link_idx = rdata_q[IDXW-1:0];
  assign link_bad = ({1'b0, link_idx} >= ENTRIES_W);

  assign job_ready_o = (state_q == BK_IDLE);
  assign init_busy_o = (state_q == BK_CLEAR) && !fmt_q;

  assign rsp_o.valid       = (state_q == BK_RESP);
  assign rsp_o.status      = status_q;
  assign rsp_o.first_block = first_q;
  assign rsp_o.next_block  = next_q;
  assign rsp_o.is_end      = end_q;
  assign rsp_o.freed_count = freed_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: if (clr_last) state_d = fmt_q ? BK_RESP : BK_IDLE;
      BK_IDLE: begin
        if (job_valid_i) begin
          unique case (job_i.op)
            OP_FORMAT: state_d = BK_CLEAR;
            OP_ALLOC:  state_d = BK_COUNT;
            OP_FREE:   state_d = BK_FREE;
            OP_LOOKUP: state_d = BK_LOOK;
            default:   state_d = BK_RESP;
          endcase
        end
      end
      BK_COUNT: begin
        priority if (hit_last) state_d = BK_LINK;
        else if (rd_last)      state_d = BK_RESP;
        else                   state_d = BK_COUNT;
      end
      BK_LINK:  if (hit_last) state_d = BK_TERM;
      BK_TERM:  state_d = BK_RESP;
      BK_FREE: begin
        if (rd_vld_q && (rd_free || link_end || link_bad)) state_d = BK_RESP;
      end
      BK_LOOK:  if (rd_vld_q) state_d = BK_RESP;
      BK_RESP:  if (rsp_o.ready) state_d = BK_IDLE;
      default:  state_d = BK_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    addr_d     = addr_q;
    iss_done_d = iss_done_q;
    fmt_d      = fmt_q;
    count_d    = count_q;
    found_d    = found_q;
    prev_d     = prev_q;
    head_d     = head_q;
    status_d   = status_q;
    first_d    = first_q;
    next_d     = next_q;
    end_d      = end_q;
    freed_d    = freed_q;
    we         = 1'b0;
    waddr      = addr_q;
    wdata      = '0;
    re         = 1'b0;
    raddr      = addr_q;

    unique case (state_q)
      BK_CLEAR: begin
        we     = 1'b1;
        wdata  = (addr_q == '0) ? END_ENTRY : '0;
        addr_d = addr_q + IDXW'(1);
      end
      BK_IDLE: begin
        if (job_valid_i) begin
          count_d    = job_i.count;
          found_d    = '0;
          status_d   = ST_OK;
          first_d    = '0;
          next_d     = '0;
          end_d      = 1'b0;
          freed_d    = '0;
          fmt_d      = 1'b0;
          iss_done_d = 1'b0;
          unique case (job_i.op)
            OP_FORMAT: begin
              addr_d = '0;
              fmt_d  = 1'b1;
            end
            OP_ALLOC:  addr_d = IDXW'(1);
            OP_FREE, OP_LOOKUP: begin
              re    = 1'b1;
              raddr = IDXW'(job_i.index);
            end
            default:   status_d = ST_BAD;
          endcase
        end
      end
      BK_COUNT, BK_LINK: begin
        // Reads run one address ahead of the data being examined
        if (!iss_done_q && !hit_last) begin
          re         = 1'b1;
          addr_d     = addr_q + IDXW'(1);
          iss_done_d = (addr_q == LAST_IDX);
        end
        if (rd_free) begin
          found_d = found_q + FIELD_W'(1);
        end
        if (state_q == BK_COUNT) begin
          if (hit_last) begin
            found_d    = '0;
            addr_d     = IDXW'(1);
            iss_done_d = 1'b0;
          end else if (rd_last) begin
            status_d = ST_NOSPACE;
          end
        end else if (rd_free) begin
          if (found_q == '0) begin
            head_d = rd_addr_q;
          end else begin
            we    = 1'b1;
            waddr = prev_q;
            wdata = {1'b0, rd_addr_q};
          end
          prev_d = rd_addr_q;
        end
      end
      BK_TERM: begin
        we      = 1'b1;
        waddr   = prev_q;
        wdata   = END_ENTRY;
        first_d = FIELD_W'(head_q);
      end
      BK_FREE: begin
        if (rd_vld_q) begin
          if (rd_free) begin
            status_d = ST_BAD;
          end else begin
            we      = 1'b1;
            waddr   = rd_addr_q;
            freed_d = freed_q + FIELD_W'(1);
            if (!link_end) begin
              if (link_bad) begin
                status_d = ST_BAD;
              end else begin
                re    = 1'b1;
                raddr = link_idx;
              end
            end
          end
        end
      end
      BK_LOOK: begin
        if (rd_vld_q) begin
          end_d  = link_end;
          next_d = FIELD_W'(link_idx);
        end
      end
      BK_RESP: ;
      default: ;
    endcase
  end

  assign rd_vld_d = re;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q   <= mem[raddr];
      rd_addr_q <= raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_CLEAR;
      addr_q     <= '0;
      iss_done_q <= 1'b0;
      fmt_q      <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      iss_done_q <= iss_done_d;
      fmt_q      <= fmt_d;
      rd_vld_q   <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    found_q  <= found_d;
    prev_q   <= prev_d;
    head_q   <= head_d;
    status_q <= status_d;
    first_q  <= first_d;
    next_q   <= next_d;
    end_q    <= end_d;
    freed_q  <= freed_d;
  end

  `FCA_ASSERT(a_link_below, (state_q == BK_LINK) |-> (found_q < count_q))
  `FCA_ASSERT_NEXT(a_term_ok, state_q == BK_TERM, state_q == BK_RESP && status_q == ST_OK)

endmodule

>>> design/fat_chain_allocator_core.sv
// Top level of the first-fit block link table allocator.
// Once a request leaves the queue, a reject goes straight to the response, a lookup reads one
// entry, an allocation runs a count scan, then a link scan, a free walks the chain, a format clears.
// One request is carried out at a time on the link table; the front queue holds 2 more.
// Reset is asynchronous active low; afterwards a clearing pass writes the table (entry 0 end
// mark, rest free) and no request is taken until it ends.
module fat_chain_allocator_core import fca_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fca_req_if.sink    req_i,
  fca_rsp_if.source  rsp_o
);

  // Front/back hand-off: one classified job per request
  logic job_valid;
  logic job_ready;
  job_t job;
  logic init_busy;

  // Front: takes requests, settles malformed ones (zero count, zero or out-of-range
  // start) and queues them, so requests keep flowing while the back is busy.
  fca_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .init_busy_i (init_busy),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // Back: owns the link table; walks it one entry per cycle for scans,
  // chain frees and format, and holds the result until the sink takes it.
  fca_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .init_busy_o (init_busy),
    .rsp_o       (rsp_o)
  );

endmodule
